// ----- rtl/pphk_pkg.sv -----
// ----------------------------------------------------------------------------
// pphk_pkg
// Shared constants, types and helpers for the pixel pattern hash key unit.
// ----------------------------------------------------------------------------
package pphk_pkg;

  // Largest pattern length that the unit counts to
  localparam int unsigned MAX_BYTES = 8192;
  localparam int unsigned LEN_W     = $clog2(MAX_BYTES + 1);

  // Fixed field widths of the channels
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned PLEN_W    = 14;
  localparam int unsigned KEY_W     = 64;

  // Hash constants
  localparam logic [31:0] HASH_M    = 32'h5bd1e995;
  localparam logic [31:0] SEED_XOR  = 32'hdeadbeef;
  localparam int unsigned HASH_R    = 24;
  localparam int unsigned FIN_R1    = 13;
  localparam int unsigned FIN_R2    = 15;

  // Datapath operations, issued by the controller one per cycle (OP_NONE while it waits)
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MIX_K1,
    OP_MIX_K2,
    OP_MIX_H,
    OP_FIN_TAIL,
    OP_FIN_MIX,
    OP_LOAD_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic lane3;     // accepted byte completes a word
    logic last;      // accepted byte ends the pattern
    logic last_r;    // byte taken earlier ended the pattern
    logic out_free;  // output register can take a key this cycle
  } dp_status_t;

  // Clamp the raw length into 1..MAX_BYTES
  function automatic logic [LEN_W-1:0] sat_len(input logic [PLEN_W-1:0] raw);
    logic [31:0] wide;
    wide = 32'(raw);
    if (wide == 32'd0) begin
      wide = 32'd1;
    end
    if (wide > 32'(MAX_BYTES)) begin
      wide = 32'(MAX_BYTES);
    end
    return wide[LEN_W-1:0];
  endfunction

endpackage

// ----- rtl/pphk_in_if.sv -----
// ----------------------------------------------------------------------------
// pphk_in_if
// Byte channel into the hash key unit: valid/ready with byte and length.
// ----------------------------------------------------------------------------
interface pphk_in_if import pphk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic [PLEN_W-1:0] pattern_length;

  modport source (output valid, output data_byte, output pattern_length, input ready);
  modport sink   (input valid, input data_byte, input pattern_length, output ready);
endinterface

// ----- rtl/pphk_out_if.sv -----
// ----------------------------------------------------------------------------
// pphk_out_if
// Key channel out of the hash key unit: valid/ready with key and error flag.
// ----------------------------------------------------------------------------
interface pphk_out_if import pphk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] topology_key;
  logic             no_pixels_error;

  modport source (output valid, output topology_key, output no_pixels_error, input ready);
  modport sink   (input valid, input topology_key, input no_pixels_error, output ready);
endinterface

// ----- rtl/pphk_ctrl.sv -----
// ----------------------------------------------------------------------------
// pphk_ctrl
// Sequencer: takes bytes, then steps the shared multiplier through the word
// mix and the final mix, and hands the key to the output register.
// ----------------------------------------------------------------------------
module pphk_ctrl import pphk_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_H,
    S_TAIL,
    S_FMIX,
    S_LOAD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Take a byte only between operations and never under reset
  assign in_ready = rst_n && (state_r == S_IDLE);

  // Decode state into the datapath operation and the next state
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op = OP_ACCEPT;
          if (status.lane3) begin
            state_nxt = S_K1;
          end else if (status.last) begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_K1: begin
        cmd.op    = OP_MIX_K1;
        state_nxt = S_K2;
      end
      S_K2: begin
        cmd.op    = OP_MIX_K2;
        state_nxt = S_H;
      end
      S_H: begin
        cmd.op    = OP_MIX_H;
        state_nxt = status.last_r ? S_FMIX : S_IDLE;
      end
      S_TAIL: begin
        cmd.op    = OP_FIN_TAIL;
        state_nxt = S_FMIX;
      end
      S_FMIX: begin
        cmd.op    = OP_FIN_MIX;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.op    = OP_LOAD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/pphk_datapath.sv -----
// ----------------------------------------------------------------------------
// pphk_datapath
// Hash state, byte packing, bitmap prefix, one shared multiply-by-M unit and
// the output register.
// ----------------------------------------------------------------------------
module pphk_datapath import pphk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic [DATA_W-1:0] data_byte,
  input  logic [PLEN_W-1:0] pattern_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KEY_W-1:0]  topology_key,
  output logic              no_pixels_error
);

  logic [31:0]      hash_r,   hash_nxt;
  logic [23:0]      word_r,   word_nxt;
  logic [31:0]      k_r,      k_nxt;
  logic [LEN_W-1:0] cnt_r,    cnt_nxt;
  logic [LEN_W-1:0] len_r,    len_nxt;
  logic [31:0]      prefix_r, prefix_nxt;
  logic             last_r,   last_nxt;
  logic             oval_r,   oval_nxt;
  logic [KEY_W-1:0] key_r,    key_nxt;
  logic             err_r,    err_nxt;

  logic             first;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] cnt_inc;
  logic [1:0]       lane;
  logic [23:0]      word_base;
  logic [31:0]      prefix_base;
  logic [31:0]      mul_a;
  logic [31:0]      product;
  logic [31:0]      k_sh;
  logic [31:0]      h_fin;

  // Decode the incoming byte's place in the pattern
  assign first   = (cnt_r == '0);
  assign len_eff = first ? sat_len(pattern_length) : len_r;
  assign cnt_inc = cnt_r + LEN_W'(1);
  assign lane    = cnt_r[1:0];

  assign status.lane3    = (lane == 2'd3);
  assign status.last     = (cnt_inc >= len_eff);
  assign status.last_r   = last_r;
  assign status.out_free = !oval_r || out_ready;

  // Select the multiplier operand; every product is by the constant M
  always_comb begin
    case (cmd.op)
      OP_MIX_K1,
      OP_MIX_K2:   mul_a = k_r;
      OP_MIX_H:    mul_a = hash_r;
      OP_FIN_TAIL: mul_a = hash_r ^ {8'd0, word_r};
      OP_FIN_MIX:  mul_a = hash_r ^ (hash_r >> FIN_R1);
      default:     mul_a = hash_r;
    endcase
  end

  assign product = mul_a * HASH_M;
  assign k_sh    = product ^ (product >> HASH_R);
  assign h_fin   = hash_r ^ (hash_r >> FIN_R2);

  // Start from a clean word and prefix on the first byte
  assign word_base   = first ? 24'd0 : word_r;
  assign prefix_base = first ? 32'd0 : prefix_r;

  // Advance the hash state for the current operation
  always_comb begin
    hash_nxt   = hash_r;
    word_nxt   = word_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    prefix_nxt = prefix_r;
    last_nxt   = last_r;
    key_nxt    = key_r;
    err_nxt    = err_r;
    oval_nxt   = out_ready ? 1'b0 : oval_r;

    case (cmd.op)
      OP_ACCEPT: begin
        if (first) begin
          len_nxt  = len_eff;
          hash_nxt = 32'(len_eff) ^ SEED_XOR;
        end
        // Capture the first four bitmap bytes, big-endian
        prefix_nxt = prefix_base;
        if (cnt_r == LEN_W'(2)) begin
          prefix_nxt[31:24] = data_byte;
        end else if (cnt_r == LEN_W'(3)) begin
          prefix_nxt[23:16] = data_byte;
        end else if (cnt_r == LEN_W'(4)) begin
          prefix_nxt[15:8] = data_byte;
        end else if (cnt_r == LEN_W'(5)) begin
          prefix_nxt[7:0] = data_byte;
        end
        // Pack bytes little-endian; the fourth byte completes a word
        word_nxt = word_base;
        case (lane)
          2'd0: word_nxt[7:0]   = data_byte;
          2'd1: word_nxt[15:8]  = data_byte;
          2'd2: word_nxt[23:16] = data_byte;
          default: begin
            k_nxt    = {data_byte, word_base};
            word_nxt = 24'd0;
          end
        endcase
        cnt_nxt  = cnt_inc;
        last_nxt = status.last;
      end
      OP_MIX_K1:   k_nxt    = k_sh;
      OP_MIX_K2:   k_nxt    = product;
      OP_MIX_H:    hash_nxt = product ^ k_r;
      OP_FIN_TAIL: hash_nxt = product;
      OP_FIN_MIX:  hash_nxt = product;
      OP_LOAD_OUT: begin
        if (len_r < LEN_W'(3)) begin
          key_nxt = '0;
          err_nxt = 1'b1;
        end else begin
          key_nxt = {h_fin, prefix_r};
          err_nxt = 1'b0;
        end
        oval_nxt = 1'b1;
        cnt_nxt  = '0;
        last_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Hold control state under reset; payload needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      last_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r   <= hash_nxt;
    word_r   <= word_nxt;
    k_r      <= k_nxt;
    len_r    <= len_nxt;
    prefix_r <= prefix_nxt;
    key_r    <= key_nxt;
    err_r    <= err_nxt;
  end

  assign out_valid       = oval_r;
  assign topology_key    = key_r;
  assign no_pixels_error = err_r;

endmodule

// ----- rtl/pixel_pattern_hash_key_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_pattern_hash_key_unit
// Hashes a cluster pattern byte by byte and emits a 64-bit topology key.
// ----------------------------------------------------------------------------
//  channel | direction | payload                          | handshake
//  in_ch   | in        | data_byte[7:0], pattern_length   | valid/ready
//  out_ch  | out       | topology_key[63:0], no_pixels_err| valid/ready
//
//  The fourth byte of each word starts the word mix, which the single
//  multiply-by-M unit runs in three passes before the next byte is taken.
//  The last byte adds the final mix: one or two multiplier passes, then
//  the load of the output register.
//  A key waiting in the output register does not block the next pattern;
//  only a second finished key waits for it to drain.
//  Reset is synchronous, active low, and leaves the unit idle.
// ----------------------------------------------------------------------------
module pixel_pattern_hash_key_unit import pphk_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pphk_in_if.sink    in_ch,
  pphk_out_if.source out_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence operations
  pphk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hash state and output register
  pphk_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .data_byte       (in_ch.data_byte),
    .pattern_length  (in_ch.pattern_length),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .topology_key    (out_ch.topology_key),
    .no_pixels_error (out_ch.no_pixels_error)
  );

endmodule

// ----- test/pphk_key_check_pkg.sv -----
// ----------------------------------------------------------------------------
// pphk_key_check_pkg
// Tracks the expected topology keys of the hash key unit: each accepted byte
// advances a bit-accurate copy of the hash, and each finished pattern queues
// the key that the unit must give.
// ----------------------------------------------------------------------------
package pphk_key_check_pkg;
  import pphk_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0] topology_key;
    logic             no_pixels_error;
  } key_item_t;

  class key_tracker;
    // Running hash state of the pattern in progress
    logic [31:0]      run_hash;
    logic [23:0]      word_acc;
    logic [LEN_W-1:0] taken;
    logic [LEN_W-1:0] pat_len;
    logic [31:0]      prefix;

    key_item_t pending_keys[$];
    int        mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      run_hash = '0;
      word_acc = '0;
      taken    = '0;
      pat_len  = '0;
      prefix   = '0;
    endfunction

    // One word round of the hash
    function logic [31:0] word_mix(logic [31:0] h, logic [31:0] k);
      k = k * HASH_M;
      k = k ^ (k >> HASH_R);
      k = k * HASH_M;
      h = h * HASH_M;
      return h ^ k;
    endfunction

    // Advance the hash by one accepted byte; queue a key when the pattern ends
    function void note_byte(logic [DATA_W-1:0] b, logic [PLEN_W-1:0] raw_len);
      logic [31:0] h;
      key_item_t   exp_key;
      int          pos;
      if (taken == '0) begin
        if (raw_len == '0) begin
          pat_len = LEN_W'(1);
        end else if (32'(raw_len) > MAX_BYTES) begin
          pat_len = LEN_W'(MAX_BYTES);
        end else begin
          pat_len = LEN_W'(raw_len);
        end
        run_hash = 32'(pat_len) ^ SEED_XOR;
        word_acc = '0;
        prefix   = '0;
      end
      pos = int'(taken);
      // Keep the first four bitmap bytes, big-endian
      if (pos >= 2 && pos <= 5) begin
        prefix[8*(5-pos) +: 8] = b;
      end
      // Fold a complete little-endian word, else hold the byte
      if (pos % 4 == 3) begin
        run_hash = word_mix(run_hash, {b, word_acc});
        word_acc = '0;
      end else begin
        word_acc[8*(pos%4) +: 8] = b;
      end
      taken = LEN_W'(pos + 1);
      if (taken < pat_len) begin
        return;
      end
      // Tail and final mix
      h = run_hash;
      if (taken[1:0] != 2'd0) begin
        h = h ^ 32'(word_acc);
        h = h * HASH_M;
      end
      h = h ^ (h >> FIN_R1);
      h = h * HASH_M;
      h = h ^ (h >> FIN_R2);
      if (pat_len < LEN_W'(3)) begin
        exp_key.topology_key    = '0;
        exp_key.no_pixels_error = 1'b1;
      end else begin
        exp_key.topology_key    = {h, prefix};
        exp_key.no_pixels_error = 1'b0;
      end
      pending_keys.push_back(exp_key);
      clear();
    endfunction

    // Compare a delivered key with the oldest expected one
    function void check_key(logic [KEY_W-1:0] key, logic err);
      key_item_t exp_key;
      if (pending_keys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected key %h error %b", key, err);
        end
        return;
      end
      exp_key = pending_keys.pop_front();
      if (exp_key.topology_key !== key || exp_key.no_pixels_error !== err) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("key mismatch: expected %h error %b, got %h error %b",
                   exp_key.topology_key, exp_key.no_pixels_error, key, err);
        end
      end
    endfunction

    function int pending();
      return pending_keys.size();
    endfunction
  endclass

endpackage

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives byte patterns into the hash key unit under several idle and stall
// mixes and checks every key against a bit-accurate hash tracker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pphk_pkg::*;
  import pphk_key_check_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_ITEMS  = 375;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic clk;
  logic rst_n;
  int   send_idle;
  int   stall_pct;
  int   cycles;

  key_tracker tracker;

  pphk_in_if  in_ch();
  pphk_out_if out_ch();

  pixel_pattern_hash_key_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[pixel_pattern_hash_key_unit] ERROR");
      $finish;
    end
  end

  // Randomly stall the key channel
  always @(posedge clk) begin
    out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Sample both handshakes between edges, bytes first
  always @(negedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      tracker.note_byte(in_ch.data_byte, in_ch.pattern_length);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.check_key(out_ch.topology_key, out_ch.no_pixels_error);
    end
  end

  // Offer one byte, idling first at random, and hold until it is taken
  task automatic send_byte(input logic [DATA_W-1:0] b, input logic [PLEN_W-1:0] len);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.pattern_length <= len;
    do begin
      @(negedge clk);
    end while (!in_ch.ready);
    @(posedge clk);
  endtask

  // Send a whole pattern; later bytes carry a random, ignored length
  task automatic send_pattern(input logic [PLEN_W-1:0] len, input fill_t fill,
                              inout int sent);
    int               n;
    int               r;
    logic [DATA_W-1:0] b;
    n = (len == '0) ? 1 : ((32'(len) > MAX_BYTES) ? MAX_BYTES : int'(len));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      case (fill)
        FILL_ONES:  b = 8'hff;
        FILL_ZEROS: b = 8'h00;
        default: begin
          b = (r < 10) ? 8'h00 : ((r < 20) ? 8'hff : DATA_W'($urandom_range(255)));
        end
      endcase
      send_byte(b, (i == 0) ? len : PLEN_W'($urandom_range(16383)));
      sent++;
    end
  endtask

  function automatic logic [PLEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 5) begin
      return PLEN_W'($urandom_range(2));
    end else if (r < 85) begin
      return PLEN_W'($urandom_range(24, 3));
    end else if (r < 97) begin
      return PLEN_W'($urandom_range(80, 25));
    end
    return PLEN_W'($urandom_range(400, 81));
  endfunction

  // Drop valid and wait for every queued key, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int sent;
    int idle_mix[4];
    int stall_mix[4];
    tracker   = new();
    idle_mix  = '{0, 88, 0, 13};
    stall_mix = '{0, 0, 88, 13};
    send_idle = 0;
    stall_pct = 0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.pattern_length = '0;
    out_ch.ready         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: short and zero lengths, extreme bytes, every tail size
    sent = 0;
    send_pattern(PLEN_W'(0), FILL_ONES, sent);
    send_pattern(PLEN_W'(1), FILL_ZEROS, sent);
    send_pattern(PLEN_W'(2), FILL_ONES, sent);
    send_pattern(PLEN_W'(3), FILL_ONES, sent);
    send_pattern(PLEN_W'(4), FILL_ZEROS, sent);
    send_pattern(PLEN_W'(6), FILL_ONES, sent);
    send_pattern(PLEN_W'(7), FILL_RANDOM, sent);
    drain();

    // Random patterns under each idle and stall mix
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_mix[ph];
      stall_pct = stall_mix[ph];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_pattern(pick_length(), FILL_RANDOM, sent);
      end
      drain();
    end

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[pixel_pattern_hash_key_unit] OK");
    end else begin
      $display("[pixel_pattern_hash_key_unit] ERROR");
    end
    $finish;
  end

endmodule
